@@ rtl/vtpd_pkg.sv @@
package vtpd_pkg;

   localparam int unsigned REG_COUNT  = 8;
   localparam int unsigned CSR_IDX_W  = 4;
   localparam int unsigned Q_BITS     = 33;
   localparam int unsigned NUM_W      = 50;
   localparam int unsigned DEN_W      = 33;
   localparam int unsigned WIDE_W     = 67;
   localparam int unsigned ROW_LAT    = 3;
   localparam int unsigned DIV_LAT    = Q_BITS + 2;
   localparam int unsigned TOTAL_LAT  = ROW_LAT + DIV_LAT;

   localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] QMIN = 32'sh8000_0000;

   localparam logic [63:0] RESET_ROW_COLS01 [0:3] = '{
      64'h0000_0000_0001_0000, 64'h0001_0000_0000_0000,
      64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000};
   localparam logic [63:0] RESET_ROW_COLS23 [0:3] = '{
      64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000,
      64'h0000_0000_0001_0000, 64'h0001_0000_0000_0000};

   typedef struct packed {
      logic [3:0][31:0] raw;
      logic             row_sat;
   } side_type;

   typedef struct packed {
      logic [31:0] proj;
      logic        sat;
   } quot_type;

endpackage

@@ rtl/vtpd_csr.sv @@
module vtpd_csr
   import vtpd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_data,
   output logic [3:0][63:0]     cols01,
   output logic [3:0][63:0]     cols23
);

   logic [3:0][63:0] cols01_ff;
   logic [3:0][63:0] cols23_ff;

   assign csr_ready = 1'b1;
   assign cols01    = cols01_ff;
   assign cols23    = cols23_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 4; r++) begin
            cols01_ff[r] <= RESET_ROW_COLS01[r];
            cols23_ff[r] <= RESET_ROW_COLS23[r];
         end
      end else if (csr_valid && csr_index < CSR_IDX_W'(REG_COUNT)) begin
         if (csr_index[0]) begin
            cols23_ff[csr_index[2:1]] <= csr_data;
         end else begin
            cols01_ff[csr_index[2:1]] <= csr_data;
         end
      end
   end

endmodule

@@ rtl/vtpd_row.sv @@
module vtpd_row
   import vtpd_pkg::*;
(
   input  logic               clock,
   input  logic               ce,
   input  logic [63:0]        cols01,
   input  logic [63:0]        cols23,
   input  logic signed [31:0] pos_x,
   input  logic signed [31:0] pos_y,
   input  logic signed [31:0] pos_z,
   output logic signed [31:0] row_out,
   output logic               row_sat
);

   logic signed [63:0]     prod_ff [0:2];
   logic signed [63:0]     prod_in [0:2];
   logic signed [31:0]     tr_ff;
   logic signed [WIDE_W-1:0] sum_ff, sum_in;
   logic signed [31:0]     res_ff, res_in;
   logic                   sat_ff, sat_in;
   logic signed [WIDE_W-1:0] rnd;

   always_comb begin
      prod_in[0] = $signed(cols01[31:0])  * pos_x;
      prod_in[1] = $signed(cols01[63:32]) * pos_y;
      prod_in[2] = $signed(cols23[31:0])  * pos_z;
      sum_in = WIDE_W'(prod_ff[0]) + WIDE_W'(prod_ff[1]) + WIDE_W'(prod_ff[2])
             + (WIDE_W'(tr_ff) <<< 16);
      rnd = (sum_ff + WIDE_W'(32768)) >>> 16;
      if (rnd > WIDE_W'(QMAX)) begin
         res_in = QMAX;
         sat_in = 1'b1;
      end else if (rnd < WIDE_W'(QMIN)) begin
         res_in = QMIN;
         sat_in = 1'b1;
      end else begin
         res_in = rnd[31:0];
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         prod_ff <= prod_in;
         tr_ff   <= $signed(cols23[63:32]);
         sum_ff  <= sum_in;
         res_ff  <= res_in;
         sat_ff  <= sat_in;
      end
   end

   assign row_out = res_ff;
   assign row_sat = sat_ff;

endmodule

@@ rtl/vtpd_div.sv @@
module vtpd_div
   import vtpd_pkg::*;
(
   input  logic               clock,
   input  logic               ce,
   input  logic signed [31:0] raw,
   input  logic signed [31:0] w,
   output quot_type           quot
);

   logic [NUM_W-1:0]  rem_ff [0:Q_BITS];
   logic [DEN_W-1:0]  den_ff [0:Q_BITS];
   logic [Q_BITS-1:0] q_ff   [0:Q_BITS];
   logic              neg_ff [0:Q_BITS];
   logic              ovf_ff [0:Q_BITS];
   logic              wz_ff  [0:Q_BITS];
   logic [31:0]       raw_ff [0:Q_BITS];
   quot_type          quot_ff, quot_in;

   logic [31:0]       abs_n, abs_d;
   logic [NUM_W-1:0]  num;
   logic [DEN_W-1:0]  den;

   always_comb begin
      abs_n = raw[31] ? 32'(-raw) : raw;
      abs_d = w[31] ? 32'(-w) : w;
      num   = (NUM_W'(abs_n) << 17) + NUM_W'(abs_d);
      den   = DEN_W'(abs_d) << 1;
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         rem_ff[0] <= num;
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         neg_ff[0] <= raw[31] ^ w[31];
         ovf_ff[0] <= WIDE_W'(num) >= (WIDE_W'(den) << Q_BITS);
         wz_ff[0]  <= (w == 32'sd0);
         raw_ff[0] <= raw;
      end
   end

   for (genvar i = 0; i < Q_BITS; i++) begin : g_step
      localparam int unsigned SH = Q_BITS - 1 - i;
      logic [WIDE_W-1:0] trial;
      logic              take;
      assign trial = WIDE_W'(den_ff[i]) << SH;
      assign take  = WIDE_W'(rem_ff[i]) >= trial;
      always_ff @(posedge clock) begin
         if (ce) begin
            rem_ff[i+1] <= take ? NUM_W'(WIDE_W'(rem_ff[i]) - trial) : rem_ff[i];
            q_ff[i+1]   <= q_ff[i] | (take ? (Q_BITS'(1) << SH) : '0);
            den_ff[i+1] <= den_ff[i];
            neg_ff[i+1] <= neg_ff[i];
            ovf_ff[i+1] <= ovf_ff[i];
            wz_ff[i+1]  <= wz_ff[i];
            raw_ff[i+1] <= raw_ff[i];
         end
      end
   end

   always_comb begin
      quot_in.sat  = 1'b0;
      quot_in.proj = raw_ff[Q_BITS];
      if (!wz_ff[Q_BITS]) begin
         if (neg_ff[Q_BITS]) begin
            if (ovf_ff[Q_BITS] || q_ff[Q_BITS] > Q_BITS'(33'h0_8000_0000)) begin
               quot_in.proj = QMIN;
               quot_in.sat  = 1'b1;
            end else begin
               quot_in.proj = 32'(-q_ff[Q_BITS]);
            end
         end else begin
            if (ovf_ff[Q_BITS] || q_ff[Q_BITS] > Q_BITS'(33'h0_7FFF_FFFF)) begin
               quot_in.proj = QMAX;
               quot_in.sat  = 1'b1;
            end else begin
               quot_in.proj = q_ff[Q_BITS][31:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

@@ rtl/vertex_transform_perspective_divide_core.sv @@
// Transforms one Q16.16 point (x, y, z, w = 1) by a 4x4 matrix and divides x, y, z by
// the resulting w. One vertex is taken every clock while the result port does not stall;
// each passes through the 3-stage multiply-accumulate rows followed by the 35-stage
// one-quotient-bit-per-stage divider. When the result port stalls, the whole pipeline
// holds. The user must write matrix registers through the csr port only while no vertex
// is in flight; the block itself does not enforce this. After reset the matrix is the identity.
module vertex_transform_perspective_divide_core
   import vtpd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_data,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [95:0]          req_tdata,   // pos_x, pos_y, pos_z
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [223:0]         rsp_tdata,   // raw_x, raw_y, raw_z, clip_w, proj_x, proj_y, proj_z
   output logic [1:0]           rsp_tuser    // w_zero, saturated
);

   logic [3:0][63:0]   cols01, cols23;
   logic               ce;
   logic [TOTAL_LAT-1:0] vld_ff;
   logic signed [31:0] row_val [0:3];
   logic [3:0]         row_sat;
   side_type           side_ff [0:DIV_LAT-1];
   quot_type           quot [0:2];
   side_type           tail;

   assign ce         = !rsp_tvalid || rsp_tready;
   assign req_tready = ce;
   assign rsp_tvalid = vld_ff[TOTAL_LAT-1];

   vtpd_csr u_csr (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .cols01, .cols23
   );

   for (genvar r = 0; r < 4; r++) begin : g_row
      vtpd_row u_row (
         .clock, .ce,
         .cols01 (cols01[r]),
         .cols23 (cols23[r]),
         .pos_x  ($signed(req_tdata[31:0])),
         .pos_y  ($signed(req_tdata[63:32])),
         .pos_z  ($signed(req_tdata[95:64])),
         .row_out(row_val[r]),
         .row_sat(row_sat[r])
      );
   end

   for (genvar c = 0; c < 3; c++) begin : g_div
      vtpd_div u_div (
         .clock, .ce,
         .raw (row_val[c]),
         .w   (row_val[3]),
         .quot(quot[c])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= {vld_ff[TOTAL_LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         side_ff[0].raw     <= {row_val[3], row_val[2], row_val[1], row_val[0]};
         side_ff[0].row_sat <= |row_sat;
         for (int i = 1; i < DIV_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign tail = side_ff[DIV_LAT-1];

   assign rsp_tdata = {quot[2].proj, quot[1].proj, quot[0].proj,
                       tail.raw[3], tail.raw[2], tail.raw[1], tail.raw[0]};
   assign rsp_tuser = {tail.row_sat | quot[0].sat | quot[1].sat | quot[2].sat,
                       tail.raw[3] == 32'd0};

endmodule

@@ verif/vertex_transform_perspective_divide_core_checker.sv @@
`timescale 1ns / 100ps

module vertex_transform_perspective_divide_core_checker
   import vtpd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_data,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [95:0]          req_tdata,   // pos_x, pos_y, pos_z
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [223:0]         rsp_tdata,   // raw_x, raw_y, raw_z, clip_w, proj_x, proj_y, proj_z
   input  logic [1:0]           rsp_tuser,   // w_zero, saturated
   output int                   errors,
   output int                   in_flight
);

   typedef struct packed {
      logic [6:0][31:0] word;
      logic             w_zero;
      logic             saturated;
   } vertex_out_type;

   logic [63:0] matrix [0:REG_COUNT-1];
   vertex_out_type vertex_q [$];

   function automatic logic signed [31:0] coef(int r, int c);
      logic [63:0] reg_val;
      reg_val = matrix[r * 2 + c / 2];
      return (c % 2) ? reg_val[63:32] : reg_val[31:0];
   endfunction

   function automatic logic signed [31:0] clamp_q16(logic signed [69:0] v, inout logic sat);
      if (v > 70'(QMAX)) begin
         sat = 1'b1;
         return QMAX;
      end
      if (v < 70'(QMIN)) begin
         sat = 1'b1;
         return QMIN;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] row_sum(int r, logic signed [31:0] p [3],
                                                  inout logic sat);
      logic signed [69:0] acc;
      logic signed [69:0] a;
      logic signed [69:0] b;
      acc = 70'(coef(r, 3)) <<< 16;
      for (int c = 0; c < 3; c++) begin
         a = 70'(coef(r, c));
         b = 70'(p[c]);
         acc = acc + a * b;
      end
      return clamp_q16((acc + 70'sd32768) >>> 16, sat);
   endfunction

   function automatic logic signed [31:0] divide_q16(logic signed [31:0] num,
                                                     logic signed [31:0] den, inout logic sat);
      logic        neg;
      logic [63:0] an;
      logic [63:0] ad;
      logic [63:0] q;
      neg = (num < 0) != (den < 0);
      an  = (num < 0) ? -64'(num) : 64'(num);
      an  = an << 16;
      ad  = (den < 0) ? -64'(den) : 64'(den);
      q   = (2 * an + ad) / (2 * ad);
      if (neg) begin
         if (q > 64'h8000_0000) begin
            sat = 1'b1;
            return QMIN;
         end
         return -q[31:0];
      end
      if (q > 64'h7FFF_FFFF) begin
         sat = 1'b1;
         return QMAX;
      end
      return q[31:0];
   endfunction

   function automatic vertex_out_type transform_vertex(logic [95:0] pos);
      vertex_out_type     v;
      logic signed [31:0] p [3];
      logic signed [31:0] row [4];
      logic             sat;
      sat = 1'b0;
      for (int i = 0; i < 3; i++) p[i] = pos[32 * i +: 32];
      for (int r = 0; r < 4; r++) row[r] = row_sum(r, p, sat);
      v.w_zero = (row[3] == 0);
      for (int r = 0; r < 4; r++) v.word[r] = row[r];
      for (int i = 0; i < 3; i++)
         v.word[4 + i] = v.w_zero ? row[i] : divide_q16(row[i], row[3], sat);
      v.saturated = sat;
      return v;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
   endtask

   initial begin
      errors    = 0;
      in_flight = 0;
   end

   always @(posedge clock) begin
      vertex_out_type want;
      if (reset) begin
         for (int r = 0; r < 4; r++) begin
            matrix[2 * r]     = RESET_ROW_COLS01[r];
            matrix[2 * r + 1] = RESET_ROW_COLS23[r];
         end
         vertex_q.delete();
         in_flight = 0;
      end else begin
         if (csr_valid && csr_ready && csr_index < REG_COUNT)
            matrix[csr_index[2:0]] = csr_data;
         if (req_tvalid && req_tready) begin
            vertex_q.push_back(transform_vertex(req_tdata));
            in_flight++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (vertex_q.size() == 0) begin
               report("unexpected vertex", rsp_tdata[31:0], 32'h0);
            end else begin
               want = vertex_q.pop_front();
               in_flight--;
               for (int i = 0; i < 7; i++)
                  if (rsp_tdata[32 * i +: 32] !== want.word[i])
                     report($sformatf("word %0d", i), rsp_tdata[32 * i +: 32], want.word[i]);
               if (rsp_tuser[0] !== want.w_zero)
                  report("w_zero", 32'(rsp_tuser[0]), 32'(want.w_zero));
               if (rsp_tuser[1] !== want.saturated)
                  report("saturated", 32'(rsp_tuser[1]), 32'(want.saturated));
            end
         end
      end
   end

endmodule

@@ verif/vertex_transform_perspective_divide_core_tb.sv @@
`timescale 1ns / 100ps

module vertex_transform_perspective_divide_core_tb;
   import vtpd_pkg::*;

   localparam int IDLE_LIMIT = 3000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0]          csr_data = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [95:0]          req_tdata = '0;   // pos_x, pos_y, pos_z
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [223:0]         rsp_tdata;        // raw_x, ..., proj_z
   logic [1:0]           rsp_tuser;        // w_zero, saturated
   int                   errors;
   int                   in_flight;
   int                   hold_asked = 0;
   int                   hold_done = 0;
   int                   stall_left = 0;
   int                   idle_cycles = 0;
   bit                   gaps_on = 1'b1;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   vertex_transform_perspective_divide_core i_dut (.*);

   vertex_transform_perspective_divide_core_checker i_checker (.*);

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_asked != hold_done) begin
         hold_done  <= hold_asked;
         stall_left <= 400;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         stall_left <= pick_gap();
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (csr_valid && csr_ready) || (req_tvalid && req_tready)
          || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("vertex_transform_perspective_divide_core_tb: done, errors");
         $finish;
      end
   end

   task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      wait (in_flight == 0);
      repeat (TOTAL_LAT + 8) @(posedge clock);
   endtask

   task automatic write_reg(int idx, logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= CSR_IDX_W'(idx);
      csr_data  <= value;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
   endtask

   task automatic load_matrix(logic [63:0] m [8]);
      for (int i = 0; i < REG_COUNT; i++) write_reg(i, m[i]);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_coord();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      if (r < 80) return $urandom;
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h0001_0000;
         4: return 32'hFFFF_FFFF;
         default: return 32'h1;
      endcase
   endfunction

   function automatic logic [31:0] pick_coef();
      if ($urandom_range(0, 9) < 8) return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      return $urandom;
   endfunction

   task automatic random_vertices(int n);
      for (int i = 0; i < n; i++) begin
         if (i % 100 == 0) gaps_on = ($urandom_range(0, 3) != 0);
         send_vertex(pick_coord(), pick_coord(), pick_coord());
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      logic [63:0] m [8];
      logic [31:0] edge_val [6];
      edge_val = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 32'h0001_0000};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // identity after reset
      foreach (edge_val[i]) send_vertex(edge_val[i], edge_val[5 - i], edge_val[(i + 2) % 6]);
      send_vertex(32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678);
      hold_asked = hold_asked + 1;
      random_vertices(300);
      drain();

      // unknown register indexes are dropped
      for (int i = REG_COUNT; i < (1 << CSR_IDX_W); i++) write_reg(i, {$urandom, $urandom});
      csr_valid <= 1'b0;
      random_vertices(20);
      drain();

      // perspective: w follows z, and the z row adds a small offset
      m = '{64'h0000_0000_0001_8000, 64'h0004_0000_0000_0000,
            64'h0001_0000_0000_0000, 64'hFFFE_0000_0000_0000,
            64'h0000_0000_0000_0000, 64'h0000_0001_FFFF_0000,
            64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000};
      load_matrix(m);
      send_vertex(32'h0001_0000, 32'h0002_0000, 32'h0);
      send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
      send_vertex(32'h0010_0000, 32'h0010_0000, 32'hFFFF_FFFF);
      send_vertex(32'h0003_0000, 32'h0, 32'h0000_0003);
      random_vertices(300);
      drain();

      // all zero: w is always zero
      foreach (m[i]) m[i] = 64'h0;
      load_matrix(m);
      send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      random_vertices(150);
      drain();

      // extreme coefficients drive rows into saturation
      foreach (m[i]) m[i] = (i % 2) ? 64'h8000_0000_7FFF_FFFF : 64'h7FFF_FFFF_8000_0000;
      load_matrix(m);
      foreach (edge_val[i]) send_vertex(edge_val[i], edge_val[i], edge_val[i]);
      random_vertices(200);
      drain();

      foreach (m[i]) m[i] = 64'hFFFF_FFFF_FFFF_FFFF;
      load_matrix(m);
      random_vertices(150);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         foreach (m[i]) m[i] = {pick_coef(), pick_coef()};
         load_matrix(m);
         if (phase == 1) hold_asked = hold_asked + 1;
         random_vertices(250);
         drain();
      end

      if (errors == 0)
         $display("vertex_transform_perspective_divide_core_tb: done, clean");
      else
         $display("vertex_transform_perspective_divide_core_tb: done, errors");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/vtpd_pkg.sv
rtl/vtpd_csr.sv
rtl/vtpd_row.sv
rtl/vtpd_div.sv
rtl/vertex_transform_perspective_divide_core.sv
verif/vertex_transform_perspective_divide_core_checker.sv
verif/vertex_transform_perspective_divide_core_tb.sv
